// ===== src/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int DATA_W = 32;
  localparam int PRIO_W = 8;
  localparam int OCC_W  = 4;

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_DEQUEUE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic        [PRIO_W-1:0] prio;
  } slot_t;

  typedef struct packed {
    op_t   op;
    slot_t item;
  } cell_ctrl_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic        [PRIO_W-1:0] prio;
    logic        [OCC_W-1:0]  occupancy;
  } result_t;

endpackage
`default_nettype wire

// ===== src/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts back on insert, forward on remove.
`default_nettype none
module spq_cell (
  input  wire logic               clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire logic               occ,
  input  wire logic               left_ge,
  input  wire spq_pkg::slot_t     left_slot,
  input  wire spq_pkg::slot_t     right_slot,
  output spq_pkg::slot_t          slot,
  output logic                    ge
);
  import spq_pkg::*;

  always_comb begin
    ge = occ && (slot.prio >= ctrl.item.prio);
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INSERT: begin
        if (!ge) begin
          slot <= left_ge ? ctrl.item : left_slot;
        end
      end
      OP_REMOVE: begin
        slot <= right_slot;
      end
      default: begin
        slot <= slot;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
// Top level: sorted priority queue built from a chain of shifting slot cells.
// Every cell compares and shifts in parallel; a transaction's result is registered once accepted.
// Throughput: one enqueue or dequeue per cycle while in_ready is high.
// A two-entry output buffer lets input proceed while one result waits to be taken.
// Reset (rst, synchronous, active high) empties the queue and clears the output buffer.
// Slot contents are not reset; only slots below the entry count are ever read.
`default_nettype none
module sorted_priority_queue #(
  parameter int DEPTH = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              command,
  input  wire logic signed [spq_pkg::DATA_W-1:0] entry_data,
  input  wire logic        [spq_pkg::PRIO_W-1:0] entry_priority,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic             [1:0]                 status,
  output logic signed [spq_pkg::DATA_W-1:0]      removed_data,
  output logic        [spq_pkg::PRIO_W-1:0]      removed_priority,
  output logic        [spq_pkg::OCC_W-1:0]       occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          full;
  logic          empty;
  logic          do_enq;
  logic          do_deq;
  cell_ctrl_t    ctrl;
  slot_t         slots [DEPTH];
  logic          ge    [DEPTH];
  result_t       res;
  result_t       out_res;
  result_t       skid_res;
  logic          skid_valid;
  logic          take;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign take     = out_valid && out_ready;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_enq   = accept && (cmd_t'(command) == CMD_ENQUEUE) && !full;
  assign do_deq   = accept && (cmd_t'(command) == CMD_DEQUEUE) && !empty;

  always_comb begin
    ctrl.item.data = entry_data;
    ctrl.item.prio = entry_priority;
    if (do_enq) begin
      ctrl.op    = OP_INSERT;
      count_next = count + CW'(1);
    end else if (do_deq) begin
      ctrl.op    = OP_REMOVE;
      count_next = count - CW'(1);
    end else begin
      ctrl.op    = OP_HOLD;
      count_next = count;
    end
  end

  always_comb begin
    if (cmd_t'(command) == CMD_ENQUEUE) begin
      res.status = full ? STATUS_FULL : STATUS_OK;
    end else begin
      res.status = empty ? STATUS_EMPTY : STATUS_OK;
    end
    res.data      = do_deq ? slots[0].data : '0;
    res.prio      = do_deq ? slots[0].prio : '0;
    res.occupancy = OCC_W'(count_next);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic  occ;
    logic  left_ge;
    slot_t left_slot;
    slot_t right_slot;

    assign occ = (CW'(i) < count);

    if (i == 0) begin : g_head
      assign left_ge   = 1'b1;
      assign left_slot = ctrl.item;
    end else begin : g_body
      assign left_ge   = ge[i-1];
      assign left_slot = slots[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_slot = slots[i];
    end else begin : g_next
      assign right_slot = slots[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ),
      .left_ge    (left_ge),
      .left_slot  (left_slot),
      .right_slot (right_slot),
      .slot       (slots[i]),
      .ge         (ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid || take) begin
        out_res <= res;
      end else begin
        skid_res <= res;
      end
    end else if (take && skid_valid) begin
      out_res <= skid_res;
    end
  end

  assign status           = out_res.status;
  assign removed_data     = out_res.data;
  assign removed_priority = out_res.prio;
  assign occupancy        = out_res.occupancy;

endmodule
`default_nettype wire

// ===== src/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
`default_nettype none
module spq_checker #(
  parameter int DEPTH = 8
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic        [1:0]                 status,
  input wire logic signed [spq_pkg::DATA_W-1:0] removed_data,
  input wire logic        [spq_pkg::PRIO_W-1:0] removed_priority,
  input wire logic        [spq_pkg::OCC_W-1:0]  occupancy
);
  import spq_pkg::*;

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_FULL) |-> occupancy == OCC_W'(DEPTH))
    else $error("full status with wrong occupancy");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_EMPTY) |->
      (occupancy == '0 && removed_data == '0 && removed_priority == '0))
    else $error("empty status with nonzero result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(status) && $stable(removed_data) && $stable(occupancy)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sorted priority queue: predicted order, status and occupancy.
`timescale 1ns / 100ps
module tb_top;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 8;
  localparam int PHASES = 31;
  localparam int PHASE_LEN = 50;

  class priority_order_tracker;
    logic signed [DATA_W-1:0] slot_data[QUEUE_DEPTH];
    logic [PRIO_W-1:0] slot_prio[QUEUE_DEPTH];
    int count = 0;
    result_t expected_results[$];
    int errors = 0;
    int checked = 0;
    int enq_ok = 0;
    int enq_full = 0;
    int deq_ok = 0;
    int deq_empty = 0;

    function void note_transaction(cmd_t cmd, logic signed [DATA_W-1:0] d,
                                   logic [PRIO_W-1:0] p);
      result_t r;
      int pos;
      r.status = STATUS_OK;
      r.data = '0;
      r.prio = '0;
      if (cmd == CMD_ENQUEUE) begin
        if (count >= QUEUE_DEPTH) begin
          r.status = STATUS_FULL;
          enq_full++;
        end else begin
          pos = 0;
          while (pos < count && slot_prio[pos] >= p) pos++;
          for (int i = count; i > pos; i--) begin
            slot_data[i] = slot_data[i-1];
            slot_prio[i] = slot_prio[i-1];
          end
          slot_data[pos] = d;
          slot_prio[pos] = p;
          count++;
          enq_ok++;
        end
      end else begin
        if (count == 0) begin
          r.status = STATUS_EMPTY;
          deq_empty++;
        end else begin
          r.data = slot_data[0];
          r.prio = slot_prio[0];
          for (int i = 1; i < count; i++) begin
            slot_data[i-1] = slot_data[i];
            slot_prio[i-1] = slot_prio[i];
          end
          count--;
          deq_ok++;
        end
      end
      r.occupancy = count[OCC_W-1:0];
      expected_results.push_back(r);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("[%0t] MISMATCH %s: got %0h expected %0h", $time, field, got, want);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic signed [DATA_W-1:0] d,
                      logic [PRIO_W-1:0] p, logic [OCC_W-1:0] occ);
      result_t r;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", {st, d, p, occ}, '0);
      end else begin
        r = expected_results.pop_front();
        checked++;
        if (st !== r.status) report_mismatch("status", st, r.status);
        if (d !== r.data) report_mismatch("removed_data", d, r.data);
        if (p !== r.prio) report_mismatch("removed_priority", p, r.prio);
        if (occ !== r.occupancy) report_mismatch("occupancy", occ, r.occupancy);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = 1'b0;
  logic signed [DATA_W-1:0] entry_data = '0;
  logic [PRIO_W-1:0] entry_priority = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic signed [DATA_W-1:0] removed_data;
  logic [PRIO_W-1:0] removed_priority;
  logic [OCC_W-1:0] occupancy;

  bit steady = 1'b0;
  priority_order_tracker tracker = new();

  sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .entry_data(entry_data),
    .entry_priority(entry_priority),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .removed_data(removed_data),
    .removed_priority(removed_priority),
    .occupancy(occupancy)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(cmd_t c, logic signed [DATA_W-1:0] d, logic [PRIO_W-1:0] p);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    entry_data <= d;
    entry_priority <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_transaction(c, d, p);
  endtask

  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      tracker.check_result(status, removed_data, removed_priority, occupancy);
    end
  end

  initial begin
    int bias;
    bit narrow;
    cmd_t c;
    logic [PRIO_W-1:0] p;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_DEQUEUE, 32'sh7fff_ffff, 8'hff);
    send_item(CMD_ENQUEUE, 32'sh8000_0000, 8'd0);
    send_item(CMD_ENQUEUE, 32'sh7fff_ffff, 8'd255);
    send_item(CMD_ENQUEUE, 32'sh5555_5555, 8'd128);
    send_item(CMD_ENQUEUE, 32'shaaaa_aaaa, 8'd128);
    send_item(CMD_ENQUEUE, -32'sd1, 8'd128);
    send_item(CMD_ENQUEUE, 32'sd0, 8'd0);
    send_item(CMD_ENQUEUE, 32'sd1, 8'd255);
    send_item(CMD_ENQUEUE, 32'sd2, 8'h55);
    send_item(CMD_ENQUEUE, 32'sd3, 8'haa);
    repeat (9) send_item(CMD_DEQUEUE, $urandom, 8'($urandom));
    send_item(CMD_ENQUEUE, 32'sh1234_5678, 8'd7);
    send_item(CMD_DEQUEUE, 32'shffff_ffff, 8'hff);
    send_item(CMD_DEQUEUE, 32'sd0, 8'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      bias = $urandom_range(15, 85);
      narrow = ($urandom_range(0, 2) == 0);
      steady = ($urandom_range(0, 3) == 0);
      repeat (PHASE_LEN) begin
        c = ($urandom_range(0, 99) < bias) ? CMD_ENQUEUE : CMD_DEQUEUE;
        p = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        send_item(c, $urandom, p);
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d enqueues (%0d dropped on full), %0d dequeues (%0d on empty).",
             tracker.enq_ok + tracker.enq_full, tracker.enq_full,
             tracker.deq_ok + tracker.deq_empty, tracker.deq_empty);
    $display("Checked %0d results with %0d mismatches.", tracker.checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
